FILE: rtl/bpcd_pkg.sv
// Shared types, constants and palette functions for the block palette code decoder.
// No dependencies; used by every module in rtl/.

package bpcd_pkg;

    localparam logic [15:0] RAW_HEADER = 16'hfeff;
    localparam int          PAL_SIZE   = 8;
    localparam logic [3:0]  LAST_POS   = 4'd15;
    localparam logic [3:0]  RAW_LAST   = 4'd1;
    localparam logic [3:0]  RAW_WORDS  = 4'd9;
    localparam logic [3:0]  FILL_WORDS = 4'd1;
    localparam logic [15:0] RAW_PLANE  = 16'h0002;

    typedef enum logic [1:0] {
        JOB_RAW   = 2'd0,
        JOB_FILL  = 2'd1,
        JOB_CODED = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] word;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [3:0]  base;
        logic [3:0]  words;
        logic [3:0]  last_cnt;
    } job_t;

    typedef logic [PAL_SIZE-1:0][7:0] pal_t;

    function automatic logic [1:0] planes_of(logic [15:0] hdr);
        logic [1:0] np;
        if (!hdr[0])
            np = 2'd1;
        else if (hdr[2:1] == 2'b11)
            np = 2'd3;
        else
            np = 2'd2;
        return np;
    endfunction

    function automatic pal_t build_palette(logic [15:0] hdr);
        logic [1:0]  np;
        logic [8:0]  s;
        logic [7:0]  p;
        logic [10:0] sum;
        logic [2:0]  f;
        pal_t        pal;
        p  = hdr[15:8];
        np = planes_of(hdr);
        if (np == 2'd1) begin
            if (hdr[7]) begin
                if (hdr[6])
                    s = 9'({hdr[5:1], 2'b00}) + 9'd131;
                else
                    s = 9'({hdr[5:1], 1'b0}) + 9'd66;
            end
            else begin
                s = 9'(hdr[6:1]) + 9'd1;
            end
        end
        else if (np == 2'd2) begin
            if (hdr[7]) begin
                if (hdr[6])
                    s = 9'({hdr[5:3], 2'b00}) + 9'd35;
                else
                    s = 9'({hdr[5:3], 1'b0}) + 9'd18;
            end
            else begin
                s = 9'(hdr[6:3]) + 9'd1;
            end
        end
        else begin
            s = 9'(hdr[7:3]) + 9'd1;
        end
        for (int k = 0; k < PAL_SIZE; k++) begin
            if (np == 2'd2 && hdr[1] && k >= 2)
                f = 3'(k + 2);
            else
                f = 3'(k);
            sum = 11'(p) + 11'(s) * 11'(f);
            pal[k] = (sum > 11'd255) ? 8'hff : sum[7:0];
        end
        return pal;
    endfunction

endpackage

FILE: rtl/bpcd_front.sv
// Front end: parses headers, raw words and code planes into decode jobs.
// Depends on bpcd_pkg.

module bpcd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       code_word,
    output logic              job_push,
    output bpcd_pkg::job_t    job,
    input  logic              job_full
);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_RAW    = 5'b00010,
        PH_PLANE0 = 5'b00100,
        PH_PLANE1 = 5'b01000,
        PH_PLANE2 = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] header_reg, header_next;
    logic [15:0] plane0_reg, plane0_next;
    logic [15:0] plane1_reg, plane1_next;
    logic [2:0]  raw_count_reg, raw_count_next;
    logic        accept;
    logic [1:0]  np;

    assign in_ready = !job_full;
    assign accept   = in_valid && !job_full;
    assign np       = bpcd_pkg::planes_of(header_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        header_next    = header_reg;
        plane0_next    = plane0_reg;
        plane1_next    = plane1_reg;
        raw_count_next = raw_count_reg;
        job_push       = 1'b0;
        job.kind       = bpcd_pkg::JOB_CODED;
        job.word       = header_reg;
        job.c0         = '0;
        job.c1         = '0;
        job.c2         = '0;
        job.base       = '0;
        job.words      = 4'(np) + 4'd1;
        job.last_cnt   = bpcd_pkg::LAST_POS;
        if (accept) begin
            unique case (phase_reg)
                PH_RAW:
                begin
                    job_push       = 1'b1;
                    job.kind       = bpcd_pkg::JOB_RAW;
                    job.word       = code_word;
                    job.c0         = bpcd_pkg::RAW_PLANE;
                    job.base       = {raw_count_reg, 1'b0};
                    job.words      = bpcd_pkg::RAW_WORDS;
                    job.last_cnt   = bpcd_pkg::RAW_LAST;
                    raw_count_next = raw_count_reg + 3'd1;
                    if (raw_count_reg == 3'd7)
                        phase_next = PH_HEADER;
                end
                PH_PLANE0:
                begin
                    plane0_next = code_word;
                    if (np == 2'd1) begin
                        job_push   = 1'b1;
                        job.c0     = code_word;
                        phase_next = PH_HEADER;
                    end
                    else begin
                        phase_next = PH_PLANE1;
                    end
                end
                PH_PLANE1:
                begin
                    plane1_next = code_word;
                    if (np == 2'd2) begin
                        job_push   = 1'b1;
                        job.c0     = plane0_reg;
                        job.c1     = code_word;
                        phase_next = PH_HEADER;
                    end
                    else begin
                        phase_next = PH_PLANE2;
                    end
                end
                PH_PLANE2:
                begin
                    job_push   = 1'b1;
                    job.c0     = plane0_reg;
                    job.c1     = plane1_reg;
                    job.c2     = code_word;
                    phase_next = PH_HEADER;
                end
                default:
                begin
                    header_next = code_word;
                    if (code_word == bpcd_pkg::RAW_HEADER) begin
                        raw_count_next = '0;
                        phase_next     = PH_RAW;
                    end
                    else if (code_word[7:0] == 8'h00) begin
                        job_push     = 1'b1;
                        job.kind     = bpcd_pkg::JOB_FILL;
                        job.word     = code_word;
                        job.words    = bpcd_pkg::FILL_WORDS;
                        phase_next   = PH_HEADER;
                    end
                    else begin
                        phase_next = PH_PLANE0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_HEADER;
            header_reg    <= '0;
            plane0_reg    <= '0;
            plane1_reg    <= '0;
            raw_count_reg <= '0;
        end
        else begin
            phase_reg     <= phase_next;
            header_reg    <= header_next;
            plane0_reg    <= plane0_next;
            plane1_reg    <= plane1_next;
            raw_count_reg <= raw_count_next;
        end
    end

endmodule

FILE: rtl/bpcd_queue.sv
// Short job queue between front end and back end.
// Depends on bpcd_pkg.

module bpcd_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bpcd_pkg::job_t    push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output bpcd_pkg::job_t    head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bpcd_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/bpcd_back.sv
// Back end: loads a job, builds its palette and emits one value per beat.
// Depends on bpcd_pkg; holds the output register.

module bpcd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  bpcd_pkg::job_t    job,
    output logic              job_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        sample,
    output logic [3:0]        sample_index,
    output logic              last,
    output logic [3:0]        words_used
);

    logic                busy_reg, busy_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    bpcd_pkg::pal_t      pal_reg;
    bpcd_pkg::pal_t      pal_load;
    logic [15:0]         c0_reg, c1_reg, c2_reg;
    logic [3:0]          base_reg, words_reg, last_cnt_reg;
    logic [7:0]          sample_reg;
    logic [3:0]          index_reg;
    logic                last_reg;
    logic [3:0]          words_used_reg;
    logic                emit;
    logic                done;
    logic                load;
    logic [2:0]          ix;
    logic [3:0]          idx;

    assign emit = busy_reg && (!out_valid_reg || out_ready);
    assign done = emit && (cnt_reg == last_cnt_reg);
    assign load = job_valid && (!busy_reg || done);
    assign job_pop = load;

    assign ix  = {c2_reg[cnt_reg], c1_reg[cnt_reg], c0_reg[cnt_reg]};
    assign idx = base_reg + cnt_reg;

    always_comb
    begin
        pal_load = '0;
        unique case (job.kind)
            bpcd_pkg::JOB_RAW:
            begin
                pal_load[0] = job.word[7:0];
                pal_load[1] = job.word[15:8];
            end
            bpcd_pkg::JOB_FILL:
            begin
                for (int k = 0; k < bpcd_pkg::PAL_SIZE; k++)
                    pal_load[k] = job.word[15:8];
            end
            default:
                pal_load = bpcd_pkg::build_palette(job.word);
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (emit) begin
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 4'd1;
        end
        if (done)
            busy_next = 1'b0;
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            pal_reg      <= pal_load;
            c0_reg       <= job.c0;
            c1_reg       <= job.c1;
            c2_reg       <= job.c2;
            base_reg     <= job.base;
            words_reg    <= job.words;
            last_cnt_reg <= job.last_cnt;
        end
        if (emit) begin
            sample_reg     <= pal_reg[ix];
            index_reg      <= idx;
            last_reg       <= (idx == bpcd_pkg::LAST_POS);
            words_used_reg <= (idx == bpcd_pkg::LAST_POS) ? words_reg : 4'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign sample_index = index_reg;
    assign last         = last_reg;
    assign words_used   = words_used_reg;

endmodule

FILE: rtl/block_palette_code_decoder_core.sv
// Top level of the block palette code decoder: front end, job queue, back end.
// Depends on bpcd_pkg, bpcd_front, bpcd_queue and bpcd_back.
//
//   channel   handshake      payload
//   input     push / full    code_word[15:0]
//   result    pop / empty    sample[7:0], sample_index[3:0], last, words_used[3:0]
//
// The back end emits one value per cycle unless pop stalls or no job waits; a raw word
// gives 2 values, fill or coded blocks 16: the value output port sets the sustained rate.
// Header and plane words parse on accept; jobs wait in a QUEUE_DEPTH-entry queue.
// full follows the job queue; a stalled pop holds the output register and backs up
// the queue. Reset clears phase, queue pointers and output valid; no clearing pass.

module block_palette_code_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_word,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  sample,
    output logic [3:0]  sample_index,
    output logic        last,
    output logic [3:0]  words_used
);

    bpcd_pkg::job_t job_in;
    bpcd_pkg::job_t job_head;
    logic           job_push;
    logic           job_full;
    logic           job_valid;
    logic           job_pop;
    logic           in_ready;
    logic           out_valid;

    assign full  = !in_ready;
    assign empty = !out_valid;

    bpcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (in_ready),
        .code_word (code_word),
        .job_push  (job_push),
        .job       (job_in),
        .job_full  (job_full)
    );

    bpcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .valid     (job_valid),
        .head      (job_head)
    );

    bpcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job_head),
        .job_pop      (job_pop),
        .out_valid    (out_valid),
        .out_ready    (pop),
        .sample       (sample),
        .sample_index (sample_index),
        .last         (last),
        .words_used   (words_used)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for block_palette_code_decoder_core: a directed table, then random blocks.
// Depends on bpcd_pkg and the rtl/ modules; expected beats come from a predictor kept here.

module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 30;
    localparam int RESET_CYCLES = 7;

    typedef enum logic [4:0] {
        DEC_HEADER = 5'b00001,
        DEC_RAW    = 5'b00010,
        DEC_PLANE0 = 5'b00100,
        DEC_PLANE1 = 5'b01000,
        DEC_PLANE2 = 5'b10000
    } dec_phase_t;

    typedef enum int {
        BLK_RAW,
        BLK_FILL,
        BLK_MONO,
        BLK_DUO,
        BLK_TRIO,
        BLK_NOISE
    } blk_kind_t;

    typedef struct packed {
        logic [7:0] sample;
        logic [3:0] index;
        logic       last;
        logic [3:0] words;
    } beat_t;

    typedef struct packed {
        logic [15:0] word;
        logic        typed;
        logic [7:0]  value;
        logic [3:0]  words;
    } stim_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] code_word = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  sample;
    logic [3:0]  sample_index;
    logic        last;
    logic [3:0]  words_used;

    dec_phase_t  dec_phase = DEC_HEADER;
    logic [15:0] hdr_q     = '0;
    logic [15:0] plane0_q  = '0;
    logic [15:0] plane1_q  = '0;
    logic [3:0]  raw_cnt   = '0;
    beat_t       step_beats [16];
    beat_t       pending_beats [$];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    stim_row_t directed_rows [25] = '{
        '{16'h0000, 1'b1, 8'h00, 4'd1},
        '{16'hff00, 1'b1, 8'hff, 4'd1},
        '{16'hfeff, 1'b0, 8'h00, 4'd0},
        '{16'h0000, 1'b0, 8'h00, 4'd0},
        '{16'hffff, 1'b0, 8'h00, 4'd0},
        '{16'h1234, 1'b0, 8'h00, 4'd0},
        '{16'ha55a, 1'b0, 8'h00, 4'd0},
        '{16'h00ff, 1'b0, 8'h00, 4'd0},
        '{16'hff00, 1'b0, 8'h00, 4'd0},
        '{16'h8001, 1'b0, 8'h00, 4'd0},
        '{16'h7ffe, 1'b0, 8'h00, 4'd0},
        '{16'h1002, 1'b0, 8'h00, 4'd0},
        '{16'ha5a5, 1'b0, 8'h00, 4'd0},
        '{16'hf0fe, 1'b0, 8'h00, 4'd0},
        '{16'hffff, 1'b0, 8'h00, 4'd0},
        '{16'h2001, 1'b0, 8'h00, 4'd0},
        '{16'h5555, 1'b0, 8'h00, 4'd0},
        '{16'h3333, 1'b0, 8'h00, 4'd0},
        '{16'h4083, 1'b0, 8'h00, 4'd0},
        '{16'h0f0f, 1'b0, 8'h00, 4'd0},
        '{16'h00ff, 1'b0, 8'h00, 4'd0},
        '{16'hffff, 1'b0, 8'h00, 4'd0},
        '{16'h1234, 1'b0, 8'h00, 4'd0},
        '{16'h8765, 1'b0, 8'h00, 4'd0},
        '{16'hffff, 1'b1, 8'hff, 4'd4}
    };

    block_palette_code_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .code_word    (code_word),
        .empty        (empty),
        .pop          (pop),
        .sample       (sample),
        .sample_index (sample_index),
        .last         (last),
        .words_used   (words_used)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int plane_count(input logic [15:0] h);
        return !h[0] ? 1 : ((h[2:1] == 2'b11) ? 3 : 2);
    endfunction

    function automatic logic [7:0] palette_entry(input logic [15:0] h, input int ix);
        int hv;
        int step;
        int pos;
        int np;
        int level;
        hv  = h;
        np  = plane_count(h);
        pos = ix;
        if (np == 1)
        begin
            if (!h[7])
                step = ((hv & 'h7e) >> 1) + 1;
            else if (!h[6])
                step = (hv & 'h3e) + 66;
            else
                step = ((hv & 'h3e) << 1) + 131;
        end
        else if (np == 2)
        begin
            if (!h[7])
                step = ((hv & 'h78) >> 3) + 1;
            else if (!h[6])
                step = ((hv & 'h38) >> 2) + 18;
            else
                step = ((hv & 'h38) >> 1) + 35;
            if (h[1] && ix >= 2)
                pos = ix + 2;
        end
        else
        begin
            step = ((hv & 'hf8) >> 3) + 1;
        end
        level = int'(h[15:8]) + pos * step;
        return (level > 255) ? 8'hff : 8'(level);
    endfunction

    function automatic beat_t make_beat(input logic [7:0] v, input logic [3:0] idx,
                                        input logic [3:0] nw);
        beat_t b;
        b.sample = v;
        b.index  = idx;
        b.last   = (idx == 4'd15);
        b.words  = b.last ? nw : 4'd0;
        return b;
    endfunction

    function automatic int coded_beats(input logic [15:0] c0, input logic [15:0] c1,
                                       input logic [15:0] c2);
        int np;
        int ix;
        np = plane_count(hdr_q);
        for (int i = 0; i < 16; i++)
        begin
            ix = int'(c0[i]);
            if (np >= 2)
                ix = ix | (int'(c1[i]) << 1);
            if (np >= 3)
                ix = ix | (int'(c2[i]) << 2);
            step_beats[i] = make_beat(palette_entry(hdr_q, ix), 4'(i), 4'(np + 1));
        end
        dec_phase = DEC_HEADER;
        return 16;
    endfunction

    function automatic int decode_word(input logic [15:0] w);
        int n;
        int np;
        n  = 0;
        np = plane_count(hdr_q);
        case (dec_phase)
            DEC_RAW:
            begin
                step_beats[0] = make_beat(w[7:0], {raw_cnt[2:0], 1'b0}, 4'd9);
                step_beats[1] = make_beat(w[15:8], {raw_cnt[2:0], 1'b1}, 4'd9);
                n = 2;
                raw_cnt = raw_cnt + 4'd1;
                if (raw_cnt >= 4'd8)
                begin
                    raw_cnt   = '0;
                    dec_phase = DEC_HEADER;
                end
            end
            DEC_PLANE0:
            begin
                plane0_q = w;
                if (np == 1)
                    n = coded_beats(w, 16'h0000, 16'h0000);
                else
                    dec_phase = DEC_PLANE1;
            end
            DEC_PLANE1:
            begin
                plane1_q = w;
                if (np == 2)
                    n = coded_beats(plane0_q, w, 16'h0000);
                else
                    dec_phase = DEC_PLANE2;
            end
            DEC_PLANE2:
            begin
                n = coded_beats(plane0_q, plane1_q, w);
            end
            default:
            begin
                hdr_q = w;
                if (w == bpcd_pkg::RAW_HEADER)
                begin
                    raw_cnt   = '0;
                    dec_phase = DEC_RAW;
                end
                else if (w[7:0] == 8'h00)
                begin
                    for (int i = 0; i < 16; i++)
                        step_beats[i] = make_beat(w[15:8], 4'(i), 4'd1);
                    n = 16;
                    dec_phase = DEC_HEADER;
                end
                else
                begin
                    dec_phase = DEC_PLANE0;
                end
            end
        endcase
        return n;
    endfunction

    task automatic send_word(input logic [15:0] w, input logic typed = 1'b0,
                             input logic [7:0] value = 8'h00, input logic [3:0] nwords = 4'd0);
        int n;
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            push      <= 1'b0;
            code_word <= 16'($urandom_range(0, 65535));
            @(negedge clk);
        end
        push      <= 1'b1;
        code_word <= w;
        do
            @(posedge clk);
        while (full);
        n = decode_word(w);
        for (int i = 0; i < n; i++)
            pending_beats.push_back(typed ? make_beat(value, 4'(i), nwords) : step_beats[i]);
        @(negedge clk);
    endtask

    task automatic send_block(inout int sent);
        blk_kind_t   kind;
        logic [15:0] hdr;
        logic [15:0] payload;
        int          pick;
        int          planes;
        pick = $urandom_range(0, 9);
        kind = (pick == 0) ? BLK_RAW : (pick == 1) ? BLK_FILL : (pick < 4) ? BLK_MONO :
               (pick < 6) ? BLK_DUO : (pick < 9) ? BLK_TRIO : BLK_NOISE;
        hdr[15:8] = 8'($urandom_range(0, 255));
        hdr[7:0]  = 8'h00;
        planes    = 0;
        case (kind)
            BLK_RAW:
            begin
                hdr    = bpcd_pkg::RAW_HEADER;
                planes = 8;
            end
            BLK_FILL:
                hdr[7:0] = 8'h00;
            BLK_MONO:
            begin
                hdr[7:0] = {7'($urandom_range(1, 127)), 1'b0};
                planes   = 1;
            end
            BLK_DUO:
            begin
                hdr[7:0] = {5'($urandom_range(0, 31)), 2'($urandom_range(0, 2)), 1'b1};
                planes   = 2;
            end
            BLK_TRIO:
            begin
                hdr[7:0] = {5'($urandom_range(0, 31)), 3'b111};
                planes   = 3;
            end
            default:
                hdr = 16'($urandom_range(0, 65535));
        endcase
        send_word(hdr);
        sent++;
        for (int k = 0; k < planes; k++)
        begin
            pick    = $urandom_range(0, 7);
            payload = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hffff :
                      16'($urandom_range(0, 65535));
            send_word(payload);
            sent++;
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending_beats.size() != 0);
    endtask

    function automatic void note_failure(input string what, input beat_t want, input beat_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%s: want sample %02h idx %0d last %0b words %0d,",
                     what, want.sample, want.index, want.last, want.words);
            $display("    got sample %02h idx %0d last %0b words %0d",
                     got.sample, got.index, got.last, got.words);
        end
    endfunction

    initial
    begin
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && pop && !empty)
        begin
            got = {sample, sample_index, last, words_used};
            if (pending_beats.size() == 0)
            begin
                note_failure("unexpected beat", got, got);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got.sample !== want.sample || got.index !== want.index ||
                    got.last !== want.last || got.words !== want.words)
                    note_failure("mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int sent;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[r])
            send_word(directed_rows[r].word, directed_rows[r].typed,
                      directed_rows[r].value, directed_rows[r].words);
        wait_drained();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:
                begin
                    sender_idle_pct = 73;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 73;
                end
                3:
                begin
                    sender_idle_pct = 24;
                    stall_pct       = 24;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
                send_block(sent);
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
